>>> src/hvt_pkg.sv
// shared widths, types and register codes for the homogeneous vertex transform
// no dependencies
package hvt_pkg;

  localparam int unsigned COEF_W     = 16;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned PROD_W     = COEF_W + COORD_W;
  localparam int unsigned PAIR_W     = PROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned N_ROWS     = 4;
  localparam int unsigned N_COLS     = 4;
  localparam int unsigned ROW_W      = N_COLS * COEF_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LATENCY    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_ONE   = 3'd0,
    CFG_ROW_TWO   = 3'd1,
    CFG_ROW_THREE = 3'd2,
    CFG_ROW_FOUR  = 3'd3
  } cfg_reg_e;

  localparam logic [ROW_W-1:0] ROW_ONE_RESET   = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW_TWO_RESET   = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW_THREE_RESET = 64'h0000_0100_0000_0000;
  localparam logic [ROW_W-1:0] ROW_FOUR_RESET  = 64'h0100_0000_0000_0000;

  typedef logic [N_COLS-1:0][COEF_W-1:0] coef_row_t;
  typedef coef_row_t [N_ROWS-1:0]        coef_mat_t;
  typedef logic [N_COLS-1:0][PROD_W-1:0] prod_row_t;
  typedef prod_row_t [N_ROWS-1:0]        prod_mat_t;
  typedef logic [N_COLS-1:0][COORD_W-1:0] vertex_t;

endpackage

>>> src/hvt_product_array.sv
// first stage: sixteen coefficient by coordinate products, registered
// depends on hvt_pkg
module hvt_product_array (
  input  logic              clk_i,
  input  hvt_pkg::coef_mat_t coef_i,
  input  hvt_pkg::vertex_t   vertex_i,
  output hvt_pkg::prod_mat_t prod_o
);
  import hvt_pkg::*;

  prod_mat_t prod_d, prod_q;

  always_comb begin
    logic signed [PROD_W-1:0] coef_ext;
    logic signed [PROD_W-1:0] coord_ext;
    for (int r = 0; r < N_ROWS; r++) begin
      for (int c = 0; c < N_COLS; c++) begin
        coef_ext     = PROD_W'($signed(coef_i[r][c]));
        coord_ext    = PROD_W'($signed(vertex_i[c]));
        prod_d[r][c] = coef_ext * coord_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> src/hvt_row_reduce.sv
// second and third stages of one row: pair sums, final sum, shift and saturate
// depends on hvt_pkg
module hvt_row_reduce (
  input  logic              clk_i,
  input  logic              negate_w_i,
  input  hvt_pkg::prod_row_t prod_i,
  output logic [hvt_pkg::OUT_W-1:0] result_o
);
  import hvt_pkg::*;

  localparam int unsigned SHIFT_W = SUM_W - FRAC_SHIFT;

  logic signed [PAIR_W-1:0]  lo_d, lo_q, hi_d, hi_q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SHIFT_W-1:0] shifted;
  logic [OUT_W-1:0]          result_d, result_q;

  always_comb begin
    lo_d = PAIR_W'($signed(prod_i[0])) + PAIR_W'($signed(prod_i[1]));
    if (negate_w_i) begin
      hi_d = PAIR_W'($signed(prod_i[2])) - PAIR_W'($signed(prod_i[3]));
    end else begin
      hi_d = PAIR_W'($signed(prod_i[2])) + PAIR_W'($signed(prod_i[3]));
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  always_comb begin
    sum     = SUM_W'(lo_q) + SUM_W'(hi_q);
    shifted = sum[SUM_W-1:FRAC_SHIFT];
    if (shifted[SHIFT_W-1:OUT_W-1] == '0 || shifted[SHIFT_W-1:OUT_W-1] == '1) begin
      result_d = shifted[OUT_W-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      result_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      result_d = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

>>> src/homogeneous_vertex_transform_core.sv
// top level of the homogeneous 4x4 vertex transform: matrix registers,
// valid and colour pipeline; depends on hvt_pkg, hvt_product_array, hvt_row_reduce
//
// One vertex may be started in every cycle; busy_o stays low. Each vertex gives
// one result on valid_o after the start beat, through the registered stages of
// multipliers, pair sums, and final sum with shift and saturation.
// The result is shown for one cycle only and cannot be held off. Matrix rows
// are written through the cfg port, always ready; write them only while no
// vertex is in flight.
module homogeneous_vertex_transform_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [hvt_pkg::COORD_W-1:0] x_in_i,
  input  logic signed [hvt_pkg::COORD_W-1:0] y_in_i,
  input  logic signed [hvt_pkg::COORD_W-1:0] z_in_i,
  input  logic signed [hvt_pkg::COORD_W-1:0] w_in_i,
  input  logic [hvt_pkg::COLOR_W-1:0]        color_in_i,
  output logic                             valid_o,
  output logic signed [hvt_pkg::OUT_W-1:0]   x_out_o,
  output logic signed [hvt_pkg::OUT_W-1:0]   y_out_o,
  output logic signed [hvt_pkg::OUT_W-1:0]   z_out_o,
  output logic signed [hvt_pkg::OUT_W-1:0]   w_out_o,
  output logic [hvt_pkg::COLOR_W-1:0]        color_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hvt_pkg::ROW_W-1:0]          cfg_data_i
);
  import hvt_pkg::*;

  coef_mat_t                       coef_q;
  vertex_t                         vertex;
  prod_mat_t                       prod;
  logic [N_ROWS-1:0][OUT_W-1:0]    row_result;
  logic                            accept;
  logic [LATENCY-1:0]              valid_d, valid_q;
  logic [LATENCY-1:0][COLOR_W-1:0] color_d, color_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= ROW_ONE_RESET;
      coef_q[1] <= ROW_TWO_RESET;
      coef_q[2] <= ROW_THREE_RESET;
      coef_q[3] <= ROW_FOUR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROW_ONE:   coef_q[0] <= cfg_data_i;
        CFG_ROW_TWO:   coef_q[1] <= cfg_data_i;
        CFG_ROW_THREE: coef_q[2] <= cfg_data_i;
        CFG_ROW_FOUR:  coef_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vertex = {w_in_i, z_in_i, y_in_i, x_in_i};

  hvt_product_array u_products (
    .clk_i    (clk_i),
    .coef_i   (coef_q),
    .vertex_i (vertex),
    .prod_o   (prod)
  );

  for (genvar r = 0; r < N_ROWS; r++) begin : g_rows
    hvt_row_reduce u_row (
      .clk_i      (clk_i),
      .negate_w_i (r != N_ROWS - 1),
      .prod_i     (prod[r]),
      .result_o   (row_result[r])
    );
  end

  assign valid_d = {valid_q[LATENCY-2:0], accept};
  assign color_d = {color_q[LATENCY-2:0], color_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign valid_o     = valid_q[LATENCY-1];
  assign color_out_o = color_q[LATENCY-1];
  assign x_out_o     = row_result[0];
  assign y_out_o     = row_result[1];
  assign z_out_o     = row_result[2];
  assign w_out_o     = row_result[3];

`ifndef SYNTH
  a_start_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 valid_o)
    else $error("started vertex produced no result");

  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 3))
    else $error("result without a started vertex");

  a_color_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 color_out_o == $past(color_in_i, 3))
    else $error("colour out of step with its vertex");
`endif

endmodule
